/* src/c16fr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// c16fr_pkg
// Shared types, constants and the CRC-16/MODBUS byte step of the frame
// receiver.
// ----------------------------------------------------------------------------
package c16fr_pkg;

    localparam int FrameLen  = 10;
    localparam int CrcSpan   = 7;
    localparam int CntW      = $clog2(CrcSpan);
    localparam int FrameIdxW = $clog2(FrameLen);
    localparam int AddrW     = 5;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    localparam logic [7:0] HeadReset = 8'hAA;
    localparam logic [7:0] EndReset  = 8'h55;
    localparam logic [7:0] JoyReset  = 8'h01;
    localparam logic [7:0] KeyReset  = 8'h02;

    localparam logic [2:0] RegHead   = 3'd0;
    localparam logic [2:0] RegEnd    = 3'd1;
    localparam logic [2:0] RegJoy    = 3'd2;
    localparam logic [2:0] RegKey    = 3'd3;
    localparam logic [2:0] RegCrcEn  = 3'd4;

    localparam logic KindJoy = 1'b0;
    localparam logic KindKey = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CRC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       clear;
        logic       step;
        logic [7:0] data;
    } t_crc_ctrl;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* src/c16fr_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// c16fr_if
// Valid/ready channels of the frame receiver: received bytes and frames.
// ----------------------------------------------------------------------------
interface c16fr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface c16fr_frame_if;
    logic       valid;
    logic       ready;
    logic       frame_kind;
    logic [7:0] payload_0;
    logic [7:0] payload_1;
    logic [7:0] payload_2;
    logic [7:0] payload_3;
    logic [7:0] payload_4;

    modport source (output valid, output frame_kind, output payload_0,
                    output payload_1, output payload_2, output payload_3,
                    output payload_4, input ready);
    modport sink   (input valid, input frame_kind, input payload_0,
                    input payload_1, input payload_2, input payload_3,
                    input payload_4, output ready);
endinterface
`default_nettype wire

/* src/c16fr_crc_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// c16fr_crc_unit
// CRC-16/MODBUS accumulator, one byte per step.
// ----------------------------------------------------------------------------
module c16fr_crc_unit
    import c16fr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_crc_ctrl   i_ctrl,
    output logic [15:0]      o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctrl.clear) begin
            n_crc = CrcInit;
        end else if (i_ctrl.step) begin
            n_crc = crc_byte(r_crc, i_ctrl.data);
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_crc = r_crc;

endmodule
`default_nettype wire

/* src/crc16_frame_receiver.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Framed serial receiver with head, type and CRC-16/MODBUS checks.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx carries one received byte per word. A byte that is not the end
//   marker, or an end marker whose frame has the wrong head, is taken
//   without making the block busy. An end marker with a matching head byte
//   makes the block busy: with CRC checking on, the CRC unit folds frame
//   bytes 0 to 6 at one byte per cycle, then the decide state follows; with
//   checking off only the decide state follows. i_rx.ready is low while
//   the block is busy.
//   o_frame carries one frame word per accepted frame from an output
//   register; new bytes are taken while it waits. If the receiver stalls
//   and a new frame is decided, the block holds in the decide state until
//   the register frees.
//   Reset clears the byte history to zeros, loads the register defaults
//   and empties the output. Registers are written through the APB port.
// ----------------------------------------------------------------------------
module crc16_frame_receiver
    import c16fr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    c16fr_byte_if.sink            i_rx,
    c16fr_frame_if.source         o_frame,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic [CntW-1:0] CntLast = CntW'(CrcSpan - 1);

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [7:0]      r_hist [FrameLen];

    logic [7:0] r_head, r_end, r_joy, r_key;
    logic       r_crc_en;

    logic       r_out_valid;
    logic       r_kind;
    logic [7:0] r_p0, r_p1, r_p2, r_p3, r_p4;

    t_crc_ctrl   w_crc_ctrl;
    logic [15:0] w_crc;
    logic        w_rx_acc, w_trigger, w_out_free, w_load_out;
    logic        w_joy, w_key, w_crc_ok, w_match, w_wr;
    logic [2:0]  w_reg;

    c16fr_crc_unit u_crc (
        .i_clk  (i_clk),
        .i_ctrl (w_crc_ctrl),
        .o_crc  (w_crc)
    );

    assign w_rx_acc   = i_rx.valid && i_rx.ready;
    assign w_trigger  = w_rx_acc && (i_rx.rx_byte == r_end) && (r_hist[1] == r_head);
    assign w_out_free = !r_out_valid || o_frame.ready;

    assign w_joy    = (r_hist[1] == r_joy);
    assign w_key    = (r_hist[1] == r_key);
    assign w_crc_ok = !r_crc_en || (w_crc == {r_hist[7], r_hist[8]});
    assign w_match  = w_crc_ok && (w_joy || w_key);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_trigger) begin
                    n_state = r_crc_en ? S_CRC : S_EMIT;
                end
            end
            S_CRC: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CntLast) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_rx.ready       = (r_state == S_IDLE);
        w_crc_ctrl.clear = w_trigger;
        w_crc_ctrl.step  = (r_state == S_CRC);
        w_crc_ctrl.data  = r_hist[FrameIdxW'(r_cnt)];
        w_load_out       = (r_state == S_EMIT) && w_out_free && w_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // shift history; frame bytes 0..8 sit in entries 0..8 after the shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FrameLen; i++) begin
                r_hist[i] <= '0;
            end
        end else if (w_rx_acc) begin
            for (int i = 0; i < FrameLen - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[FrameLen-1] <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_kind <= w_joy ? KindJoy : KindKey;
            r_p0   <= r_hist[2];
            r_p1   <= r_hist[3];
            r_p2   <= r_hist[4];
            r_p3   <= w_joy ? r_hist[5] : 8'h00;
            r_p4   <= w_joy ? r_hist[6] : 8'h00;
        end
    end

    assign o_frame.valid      = r_out_valid;
    assign o_frame.frame_kind = r_kind;
    assign o_frame.payload_0  = r_p0;
    assign o_frame.payload_1  = r_p1;
    assign o_frame.payload_2  = r_p2;
    assign o_frame.payload_3  = r_p3;
    assign o_frame.payload_4  = r_p4;

    assign pready = 1'b1;
    assign w_reg  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= HeadReset;
            r_end    <= EndReset;
            r_joy    <= JoyReset;
            r_key    <= KeyReset;
            r_crc_en <= 1'b1;
        end else if (w_wr) begin
            case (w_reg)
                RegHead:  r_head   <= pwdata[7:0];
                RegEnd:   r_end    <= pwdata[7:0];
                RegJoy:   r_joy    <= pwdata[7:0];
                RegKey:   r_key    <= pwdata[7:0];
                RegCrcEn: r_crc_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            RegHead:  prdata = {24'h0, r_head};
            RegEnd:   prdata = {24'h0, r_end};
            RegJoy:   prdata = {24'h0, r_joy};
            RegKey:   prdata = {24'h0, r_key};
            RegCrcEn: prdata = {31'h0, r_crc_en};
            default:  prdata = 32'h0;
        endcase
    end

    a_crc_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRC && r_cnt == CntLast) |=> (r_state == S_EMIT))
        else $error("CRC pass did not end in decide");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRC) |-> (r_cnt <= CntLast))
        else $error("CRC byte counter out of range");

    a_crc_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_trigger && r_crc_en) |=> (w_crc == CrcInit && r_cnt == '0))
        else $error("CRC unit not seeded on trigger");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !o_frame.ready)
        |=> (r_state == S_EMIT && r_out_valid))
        else $error("decided frame dropped while output stalled");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_hist[FrameLen-1]) || $past(r_state) == S_IDLE)
        else $error("history moved while busy");

endmodule
`default_nettype wire

/* tb/c16fr_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c16fr_tb_pkg
// Frame word type and CRC-16/MODBUS over the seven checked frame bytes,
// shared by the stimulus and the checker of the frame receiver bench.
// ----------------------------------------------------------------------------
package c16fr_tb_pkg;
    import c16fr_pkg::*;

    typedef struct packed {
        logic       frame_kind;
        logic [7:0] payload_0;
        logic [7:0] payload_1;
        logic [7:0] payload_2;
        logic [7:0] payload_3;
        logic [7:0] payload_4;
    } t_frame;

    // Byte i of the span sits at bits 8*i+7 .. 8*i.
    function automatic logic [15:0] modbus_crc16(input logic [8*CrcSpan-1:0] span);
        logic [15:0] acc;
        acc = CrcInit;
        for (int i = 0; i < CrcSpan; i++) begin
            acc = acc ^ {8'h00, span[8*i +: 8]};
            for (int b = 0; b < 8; b++) begin
                if (acc[0]) begin
                    acc = (acc >> 1) ^ CrcPoly;
                end else begin
                    acc = acc >> 1;
                end
            end
        end
        return acc;
    endfunction

endpackage

/* tb/c16fr_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c16fr_checker
// Watches the byte, frame and APB ports of the frame receiver, keeps its own
// byte history and register copy, predicts the frame word of every accepted
// frame and compares each delivered frame word field by field in order.
// ----------------------------------------------------------------------------
module c16fr_checker
    import c16fr_pkg::*;
    import c16fr_tb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    c16fr_byte_if                 i_rx,
    c16fr_frame_if                i_frame,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [31:0]      pwdata,
    input  wire logic             pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int HistDepth = FrameLen - 1;

    logic [7:0] history [HistDepth];
    logic [7:0] head_cfg;
    logic [7:0] eom_cfg;
    logic [7:0] joy_cfg;
    logic [7:0] key_cfg;
    logic       crc_en_cfg;
    t_frame     frames_due [$];
    int         fails = 0;

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %02h, actual %02h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        logic [8*CrcSpan-1:0] span;
        logic                 crc_ok;
        t_frame               want;
        t_frame               got;
        if (!i_rst_n) begin
            for (int i = 0; i < HistDepth; i++) begin
                history[i] = 8'h00;
            end
            head_cfg   = HeadReset;
            eom_cfg    = EndReset;
            joy_cfg    = JoyReset;
            key_cfg    = KeyReset;
            crc_en_cfg = 1'b1;
            frames_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[AddrW-1:2])
                    RegHead:  head_cfg   = pwdata[7:0];
                    RegEnd:   eom_cfg    = pwdata[7:0];
                    RegJoy:   joy_cfg    = pwdata[7:0];
                    RegKey:   key_cfg    = pwdata[7:0];
                    RegCrcEn: crc_en_cfg = pwdata[0];
                    default: ;
                endcase
            end
            if (i_rx.valid && i_rx.ready) begin
                for (int i = 0; i < CrcSpan; i++) begin
                    span[8*i +: 8] = history[i];
                end
                crc_ok = !crc_en_cfg || (modbus_crc16(span) == {history[7], history[8]});
                if (i_rx.rx_byte == eom_cfg && history[0] == head_cfg && crc_ok) begin
                    want.payload_0 = history[2];
                    want.payload_1 = history[3];
                    want.payload_2 = history[4];
                    if (history[1] == joy_cfg) begin
                        want.frame_kind = KindJoy;
                        want.payload_3  = history[5];
                        want.payload_4  = history[6];
                        frames_due.push_back(want);
                    end else if (history[1] == key_cfg) begin
                        want.frame_kind = KindKey;
                        want.payload_3  = 8'h00;
                        want.payload_4  = 8'h00;
                        frames_due.push_back(want);
                    end
                end
                for (int i = 0; i < HistDepth - 1; i++) begin
                    history[i] = history[i+1];
                end
                history[HistDepth-1] = i_rx.rx_byte;
            end
            if (i_frame.valid && i_frame.ready) begin
                got = {i_frame.frame_kind, i_frame.payload_0, i_frame.payload_1,
                       i_frame.payload_2, i_frame.payload_3, i_frame.payload_4};
                if (frames_due.size() == 0) begin
                    $display("%0t: frame expected none, actual %h", $time, got);
                    fails++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("frame_kind", {7'h00, want.frame_kind},
                                {7'h00, got.frame_kind});
                    check_field("payload_0", want.payload_0, got.payload_0);
                    check_field("payload_1", want.payload_1, got.payload_1);
                    check_field("payload_2", want.payload_2, got.payload_2);
                    check_field("payload_3", want.payload_3, got.payload_3);
                    check_field("payload_4", want.payload_4, got.payload_4);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= frames_due.size();
    end

endmodule

/* tb/crc16_frame_receiver_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc16_frame_receiver_tb
// Drives the frame receiver with directed frames at register extremes, then
// phases of random well-formed, corrupted and noise byte streams under
// changing register settings, with random idling on both channels outside the last phase.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_tb;
    import c16fr_pkg::*;
    import c16fr_tb_pkg::*;

    localparam int         StallLimit  = 2000;
    localparam int         Phases      = 8;
    localparam int         PhaseBytes  = 230;
    localparam int         DrainCycles = 24;
    localparam logic [2:0] RegUnused   = 3'd7;

    logic             i_clk;
    logic             i_rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    int               fail_count;
    int               frames_due;
    int               idle_cycles = 0;
    int               bytes_sent  = 0;
    bit               quiet       = 1'b0;
    logic [7:0]       head_cfg;
    logic [7:0]       eom_cfg;
    logic [7:0]       joy_cfg;
    logic [7:0]       key_cfg;

    c16fr_byte_if  rx_if();
    c16fr_frame_if frame_if();

    crc16_frame_receiver DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_frame (frame_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    c16fr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_if),
        .i_frame      (frame_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (frames_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        frame_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            frame_if.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            if (!quiet) begin
                frame_if.ready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (rx_if.valid && rx_if.ready) ||
            (frame_if.valid && frame_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] type_code, input logic [39:0] payload,
                              input bit head_ok, input bit crc_ok);
        logic [7:0]           fr [FrameLen];
        logic [8*CrcSpan-1:0] span;
        logic [15:0]          crc;
        fr[0] = head_ok ? head_cfg : head_cfg ^ 8'($urandom_range(1, 255));
        fr[1] = type_code;
        for (int i = 0; i < 5; i++) begin
            fr[2+i] = payload[8*i +: 8];
        end
        for (int i = 0; i < CrcSpan; i++) begin
            span[8*i +: 8] = fr[i];
        end
        crc = modbus_crc16(span);
        if (!crc_ok) begin
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        end
        fr[7] = crc[15:8];
        fr[8] = crc[7:0];
        fr[9] = eom_cfg;
        for (int i = 0; i < FrameLen; i++) begin
            send_byte(fr[i]);
        end
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] head, input logic [7:0] eom,
                              input logic [7:0] joy, input logic [7:0] key,
                              input logic crc_en);
        logic [31:0] junk;
        junk = $urandom;
        apb_write(RegHead, {junk[31:8], head});
        apb_write(RegEnd, {junk[23:0], eom});
        apb_write(RegJoy, {junk[7:0], junk[31:16], joy});
        apb_write(RegKey, {junk[15:0], junk[31:24], key});
        apb_write(RegCrcEn, {junk[31:1], crc_en});
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        head_cfg = head;
        eom_cfg  = eom;
        joy_cfg  = joy;
        key_cfg  = key;
    endtask

    // hold until every frame is out and the block has finished any check
    task automatic drain();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (frames_due != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          start;
        int          pick;
        logic [7:0]  code;
        logic [39:0] payload;
        logic [31:0] r;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = 8'h00;
        head_cfg       = HeadReset;
        eom_cfg        = EndReset;
        joy_cfg        = JoyReset;
        key_cfg        = KeyReset;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // end marker on an all-zero history, equal type codes, no CRC check
        set_config(8'h00, EndReset, 8'h00, 8'h00, 1'b0);
        send_byte(EndReset);
        drain();
        set_config(8'hFF, 8'h00, 8'hFF, 8'h80, 1'b1);
        apb_write(RegUnused, $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        send_frame(8'h80, 40'hFF_FFFF_FFFF, 1'b1, 1'b1);
        // end markers inside the payload
        send_frame(8'hFF, 40'h00_1200_0034, 1'b1, 1'b1);

        for (int p = 0; p < Phases; p++) begin
            drain();
            r = $urandom;
            case (p)
                0: set_config(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
                1: set_config(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
                2: set_config(r[7:0], r[15:8], r[23:16], r[23:16], 1'b1);
                3: set_config(HeadReset, EndReset, JoyReset, KeyReset, 1'b1);
                default: set_config(r[7:0], r[15:8], r[23:16], r[31:24],
                                    $urandom_range(0, 3) != 0);
            endcase
            quiet = (p == Phases - 1);
            start = bytes_sent;
            while (bytes_sent - start < PhaseBytes) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    pick = $urandom_range(0, 4);
                    if (pick < 2) begin
                        code = joy_cfg;
                    end else if (pick < 4) begin
                        code = key_cfg;
                    end else begin
                        code = 8'($urandom);
                        while (code == joy_cfg || code == key_cfg) code = 8'($urandom);
                    end
                    payload = {8'($urandom), $urandom};
                    send_frame(code, payload, $urandom_range(0, 9) != 0,
                               $urandom_range(0, 6) != 0);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte($urandom_range(0, 3) == 0 ? eom_cfg : 8'($urandom));
                    end
                end
            end
        end
        drain();

        if (fail_count == 0 && frames_due == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
